@@ rtl/wpo_pkg.sv @@
// ----------------------------------------------------------------------------
// wpo_pkg
// Shared constants and the detune factor ROM of the wavetable oscillator.
// ----------------------------------------------------------------------------
package wpo_pkg;

  localparam int TABLE_DEPTH = 2048;
  localparam int PHASE_BITS  = 32;
  localparam int TABLE_COUNT = 4;

  localparam int BASE_STEP_BITS = 31;
  localparam int DETUNE_BITS    = 7;
  localparam int WAVEFORM_BITS  = 2;
  localparam int GAIN_BITS      = 16;
  localparam int CFG_DATA_BITS  = 31;
  localparam int CFG_INDEX_BITS = 2;

  localparam int ADDR_FIELD_BITS = 11;
  localparam int SAMPLE_BITS     = 16;
  localparam int FRAC_BITS       = 16;
  localparam int FACTOR_BITS     = 17;
  localparam int STEP_BITS       = 32;

  localparam int DETUNE_MAX     = 50;
  localparam int DETUNE_ENTRIES = 2 * DETUNE_MAX + 1;
  localparam int DETUNE_IDX_BITS = $clog2(DETUNE_ENTRIES);

  localparam logic [GAIN_BITS-1:0] GAIN_UNITY = 16'd32768;

  localparam logic [63:0] ONE_Q30       = 64'd1073741824;
  localparam logic [63:0] CENT_UP_Q30   = 64'd1074362221;
  localparam logic [63:0] CENT_DOWN_Q30 = 64'd1073121785;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BASE_STEP = 2'd0,
    REG_DETUNE    = 2'd1,
    REG_WAVEFORM  = 2'd2,
    REG_GAIN      = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    MODE_TICK  = 1'b0,
    MODE_WRITE = 1'b1
  } item_mode_t;

  typedef logic [FACTOR_BITS-1:0] detune_rom_t [DETUNE_ENTRIES];

  // Q1.16 factor per cent, built by repeated Q2.30 multiplication.
  function automatic detune_rom_t build_detune_rom();
    detune_rom_t rom;
    logic [63:0] v;
    logic [63:0] r;
    int n;
    for (int c = 0; c < DETUNE_ENTRIES; c++) begin
      v = ONE_Q30;
      r = CENT_UP_Q30;
      n = c - DETUNE_MAX;
      if (n < 0) begin
        r = CENT_DOWN_Q30;
        n = -n;
      end
      for (int k = 0; k < n; k++) begin
        v = (v * r + (64'd1 << 29)) >> 30;
      end
      rom[c] = FACTOR_BITS'((v + (64'd1 << 13)) >> 14);
    end
    return rom;
  endfunction

  localparam detune_rom_t DETUNE_ROM = build_detune_rom();

endpackage

@@ rtl/wpo_ram.sv @@
// ----------------------------------------------------------------------------
// wpo_ram
// Generic RAM: one write port, two read ports, registered read with enable.
// ----------------------------------------------------------------------------
module wpo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ rtl/wavetable_phase_oscillator_core.sv @@
// ----------------------------------------------------------------------------
// wavetable_phase_oscillator_core
// Phase-accumulating wavetable oscillator with linear interpolation and gain.
// ----------------------------------------------------------------------------
// Input channel (item_valid/item_ready): a beat with mode tick advances the
// phase and yields one sample; a beat with mode write stores table_value at
// table_addr of table table_select and yields nothing.
// Output channel (sample_valid/sample_ready): one beat per tick, in order.
// Configuration: cfg_write with cfg_index/cfg_data sets base_step, detune,
// waveform and gain; write only while no beat is in flight.
// Throughput: one beat per cycle while the receiver takes samples. The phase
// add is a single-register loop; lookup, interpolation, gain and rounding run
// in a pipeline behind it. A sample is registered through the table access,
// blend and gain stages; a table write lands in the store at table access.
// The wave store is one RAM of 4 x TABLE_DEPTH entries; a beat either writes
// one entry or reads two; entries hold no value until written.
// Reset clears phase, valid flags, base_step and waveform; sets gain and factor to unity.
// When the receiver stalls the whole pipeline holds and item_ready drops.
// ----------------------------------------------------------------------------
module wavetable_phase_oscillator_core #(
  parameter int TABLE_DEPTH = wpo_pkg::TABLE_DEPTH,
  parameter int PHASE_BITS  = wpo_pkg::PHASE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [wpo_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [wpo_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  logic                                 mode,
  input  logic [1:0]                           table_select,
  input  logic [wpo_pkg::ADDR_FIELD_BITS-1:0]  table_addr,
  input  logic signed [wpo_pkg::SAMPLE_BITS-1:0] table_value,
  output logic                                 sample_valid,
  input  logic                                 sample_ready,
  output logic signed [wpo_pkg::SAMPLE_BITS-1:0] sample
);

  localparam int ADDR_BITS = $clog2(TABLE_DEPTH);
  localparam int MEM_DEPTH = wpo_pkg::TABLE_COUNT * TABLE_DEPTH;
  localparam int MEM_ABITS = $clog2(MEM_DEPTH);
  localparam int FRAC_LSB  = PHASE_BITS - ADDR_BITS;
  localparam int MUL_BITS  = wpo_pkg::BASE_STEP_BITS + wpo_pkg::FACTOR_BITS;
  localparam int AF        = wpo_pkg::ADDR_FIELD_BITS;
  localparam int SW        = wpo_pkg::SAMPLE_BITS;

  // configuration
  logic [wpo_pkg::BASE_STEP_BITS-1:0] base_step;
  logic [wpo_pkg::FACTOR_BITS-1:0]    factor;
  logic [wpo_pkg::WAVEFORM_BITS-1:0]  waveform;
  logic [wpo_pkg::GAIN_BITS-1:0]      gain;

  logic signed [wpo_pkg::DETUNE_BITS-1:0]   cents_in;
  logic signed [wpo_pkg::DETUNE_BITS:0]     cents_clamped;
  logic [wpo_pkg::DETUNE_IDX_BITS-1:0]      detune_idx;
  logic [wpo_pkg::GAIN_BITS-1:0]            gain_clamped;

  always_comb begin
    cents_in = $signed(cfg_data[wpo_pkg::DETUNE_BITS-1:0]);
    cents_clamped = (wpo_pkg::DETUNE_BITS + 1)'(cents_in);
    if (cents_in > $signed(7'(wpo_pkg::DETUNE_MAX))) begin
      cents_clamped = (wpo_pkg::DETUNE_BITS + 1)'(wpo_pkg::DETUNE_MAX);
    end else if (cents_in < -$signed(7'(wpo_pkg::DETUNE_MAX))) begin
      cents_clamped = -(wpo_pkg::DETUNE_BITS + 1)'(wpo_pkg::DETUNE_MAX);
    end
    detune_idx = wpo_pkg::DETUNE_IDX_BITS'(cents_clamped
                 + (wpo_pkg::DETUNE_BITS + 1)'(wpo_pkg::DETUNE_MAX));
    gain_clamped = cfg_data[wpo_pkg::GAIN_BITS-1:0];
    if (gain_clamped > wpo_pkg::GAIN_UNITY) begin
      gain_clamped = wpo_pkg::GAIN_UNITY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_step <= '0;
      factor    <= wpo_pkg::DETUNE_ROM[wpo_pkg::DETUNE_MAX];
      waveform  <= '0;
      gain      <= wpo_pkg::GAIN_UNITY;
    end else if (cfg_write) begin
      unique case (wpo_pkg::cfg_reg_t'(cfg_index))
        wpo_pkg::REG_BASE_STEP: base_step <= cfg_data;
        wpo_pkg::REG_DETUNE:    factor    <= wpo_pkg::DETUNE_ROM[detune_idx];
        wpo_pkg::REG_WAVEFORM:  waveform  <= cfg_data[wpo_pkg::WAVEFORM_BITS-1:0];
        wpo_pkg::REG_GAIN:      gain      <= gain_clamped;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic adv;
  assign adv        = !sample_valid || sample_ready;
  assign item_ready = adv;

  // stage 1: step product
  logic                 p1_valid, p1_mode;
  logic [1:0]           p1_sel;
  logic [AF-1:0]        p1_addr;
  logic signed [SW-1:0] p1_value;
  logic [MUL_BITS-1:0]  p1_mul;

  // stage 2: rounded step
  logic                 p2_valid, p2_mode;
  logic [1:0]           p2_sel;
  logic [AF-1:0]        p2_addr;
  logic signed [SW-1:0] p2_value;
  logic [PHASE_BITS-1:0] p2_step;
  logic [MUL_BITS-1:0]  step_round;

  // stage 3: table access
  logic                 p3_valid, p3_mode;
  logic [1:0]           p3_sel;
  logic [AF-1:0]        p3_addr;
  logic signed [SW-1:0] p3_value;
  logic [PHASE_BITS-1:0] phase;

  logic [PHASE_BITS+wpo_pkg::FRAC_BITS-1:0] phase_ext;
  logic [wpo_pkg::FRAC_BITS-1:0] frac;
  logic [ADDR_BITS-1:0]  idx0, idx1, wr_idx;
  logic                  addr_ok, ram_we, ram_re;
  logic [MEM_ABITS-1:0]  ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [SW-1:0]         rd_a, rd_b;

  // stages 4..7 and output
  logic                  p4_valid;
  logic [wpo_pkg::FRAC_BITS-1:0] p4_frac;
  logic [wpo_pkg::FRAC_BITS:0]   w_a;
  logic                  p5_valid;
  logic signed [33:0]    p5_prod_a, p5_prod_b;
  logic                  p6_valid;
  logic signed [33:0]    p6_blend;
  logic                  p7_valid;
  logic signed [50:0]    p7_scaled;
  logic signed [50:0]    rounded;
  logic signed [19:0]    y;
  logic signed [SW-1:0]  y_sat;

  assign step_round = p1_mul + MUL_BITS'(32768);

  always_comb begin
    phase_ext   = {phase, wpo_pkg::FRAC_BITS'(0)};
    frac        = phase_ext[FRAC_LSB +: wpo_pkg::FRAC_BITS];
    idx0        = phase[PHASE_BITS-1 -: ADDR_BITS];
    idx1        = idx0 + ADDR_BITS'(1);
    wr_idx      = ADDR_BITS'(p3_addr);
    addr_ok     = 32'(p3_addr) < 32'(TABLE_DEPTH);
    ram_we      = adv && p3_valid && (p3_mode == wpo_pkg::MODE_WRITE) && addr_ok;
    ram_re      = adv && p3_valid && (p3_mode == wpo_pkg::MODE_TICK);
    ram_waddr   = {p3_sel, wr_idx};
    ram_raddr_a = {waveform, idx0};
    ram_raddr_b = {waveform, idx1};
    w_a         = (wpo_pkg::FRAC_BITS + 1)'(65536) - {1'b0, p4_frac};
    rounded     = p7_scaled + 51'sd1073741824;
    y           = rounded[50:31];
    if (y > 20'sd32767) begin
      y_sat = 16'sd32767;
    end else if (y < -20'sd32768) begin
      y_sat = -16'sd32768;
    end else begin
      y_sat = y[SW-1:0];
    end
  end

  wpo_ram #(
    .WIDTH (SW),
    .DEPTH (MEM_DEPTH)
  ) u_wave_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (p3_value),
    .re      (ram_re),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid     <= 1'b0;
      p2_valid     <= 1'b0;
      p3_valid     <= 1'b0;
      p4_valid     <= 1'b0;
      p5_valid     <= 1'b0;
      p6_valid     <= 1'b0;
      p7_valid     <= 1'b0;
      sample_valid <= 1'b0;
      phase        <= '0;
    end else if (adv) begin
      p1_valid     <= item_valid;
      p2_valid     <= p1_valid;
      p3_valid     <= p2_valid;
      p4_valid     <= p3_valid && (p3_mode == wpo_pkg::MODE_TICK);
      p5_valid     <= p4_valid;
      p6_valid     <= p5_valid;
      p7_valid     <= p6_valid;
      sample_valid <= p7_valid;
      if (p2_valid && (p2_mode == wpo_pkg::MODE_TICK)) begin
        phase <= phase + p2_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_mode   <= mode;
      p1_sel    <= table_select;
      p1_addr   <= table_addr;
      p1_value  <= table_value;
      p1_mul    <= MUL_BITS'(base_step) * MUL_BITS'(factor);
      p2_mode   <= p1_mode;
      p2_sel    <= p1_sel;
      p2_addr   <= p1_addr;
      p2_value  <= p1_value;
      p2_step   <= PHASE_BITS'(step_round[MUL_BITS-1:16]);
      p3_mode   <= p2_mode;
      p3_sel    <= p2_sel;
      p3_addr   <= p2_addr;
      p3_value  <= p2_value;
      p4_frac   <= frac;
      p5_prod_a <= $signed(rd_a) * $signed({1'b0, w_a});
      p5_prod_b <= $signed(rd_b) * $signed({2'b0, p4_frac});
      p6_blend  <= p5_prod_a + p5_prod_b;
      p7_scaled <= p6_blend * $signed({1'b0, gain});
      sample    <= y_sat;
    end
  end

  // checks
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    gain <= wpo_pkg::GAIN_UNITY)
    else $error("gain above unity");

  a_factor_range: assert property (@(posedge clk) disable iff (rst)
    factor >= wpo_pkg::DETUNE_ROM[0] &&
    factor <= wpo_pkg::DETUNE_ROM[wpo_pkg::DETUNE_ENTRIES-1])
    else $error("detune factor out of range");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !(adv && p2_valid && (p2_mode == wpo_pkg::MODE_TICK)) |=> $stable(phase))
    else $error("phase moved without a tick");

  a_sample_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(sample_valid) |-> $past(p7_valid))
    else $error("sample beat without a tick behind it");

  a_no_read_on_write: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("wave store written and read by one beat");

endmodule

@@ tb/sv/wavetable_phase_oscillator_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavetable_phase_oscillator_core_tb
// Drives tick and table-write beats through the oscillator under random
// handshake gaps, predicts each sample from a local phase accumulator, tables
// and register copy, and compares every sample beat in order.
// ----------------------------------------------------------------------------
module wavetable_phase_oscillator_core_tb;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SAW      = 2'd1,
    WAVE_SQUARE   = 2'd2,
    WAVE_TRIANGLE = 2'd3
  } wave_t;

  localparam int SETTLE_CYCLES = 12;

  class osc_sample_tracker;
    logic [30:0]        step_base;
    int                 detune;
    wave_t              wave_sel;
    longint             gain_q15;
    logic [31:0]        phase;
    logic [63:0]        cent_factor [101];
    logic signed [15:0] wave_mem [4][2048];
    bit                 loaded [4][2048];
    logic signed [15:0] pending_samples [$];
    int unsigned        errors;
    int unsigned        compared;
    int unsigned        tick_count;
    int unsigned        write_count;

    function new();
      logic [63:0] v;
      logic [63:0] r;
      int n;
      for (int c = -50; c <= 50; c++) begin
        v = wpo_pkg::ONE_Q30;
        r = (c < 0) ? wpo_pkg::CENT_DOWN_Q30 : wpo_pkg::CENT_UP_Q30;
        n = (c < 0) ? -c : c;
        for (int k = 0; k < n; k++) begin
          v = (v * r + (64'd1 << 29)) >> 30;
        end
        cent_factor[c + 50] = (v + (64'd1 << 13)) >> 14;
      end
      step_base = '0;
      detune    = 0;
      wave_sel  = WAVE_SINE;
      gain_q15  = longint'(wpo_pkg::GAIN_UNITY);
      phase     = '0;
    endfunction

    function void configure(wpo_pkg::cfg_reg_t idx, logic [30:0] data);
      int raw;
      logic [15:0] g;
      case (idx)
        wpo_pkg::REG_BASE_STEP: begin
          step_base = data;
        end
        wpo_pkg::REG_DETUNE: begin
          raw = int'($signed(data[6:0]));
          detune = (raw > 50) ? 50 : ((raw < -50) ? -50 : raw);
        end
        wpo_pkg::REG_WAVEFORM: begin
          wave_sel = wave_t'(data[1:0]);
        end
        wpo_pkg::REG_GAIN: begin
          g = data[15:0];
          gain_q15 = (g > wpo_pkg::GAIN_UNITY) ? longint'(wpo_pkg::GAIN_UNITY)
                                                : longint'(g);
        end
        default: ;
      endcase
    endfunction

    function logic [31:0] next_phase();
      logic [63:0] inc;
      inc = ({33'd0, step_base} * cent_factor[detune + 50] + 64'd32768) >> 16;
      return phase + inc[31:0];
    endfunction

    // entries the next tick will blend
    function void next_reads(output logic [10:0] lo, output logic [10:0] hi);
      logic [31:0] ph;
      ph = next_phase();
      lo = ph[31:21];
      hi = lo + 11'd1;
    endfunction

    function void accept_item(wpo_pkg::item_mode_t m, logic [1:0] sel,
                              logic [10:0] addr, logic signed [15:0] val);
      logic [10:0] lo;
      logic [10:0] hi;
      longint a;
      longint b;
      longint frac;
      longint blend;
      longint prod;
      if (m == wpo_pkg::MODE_WRITE) begin
        wave_mem[sel][addr] = val;
        loaded[sel][addr] = 1'b1;
        write_count++;
        return;
      end
      phase = next_phase();
      lo    = phase[31:21];
      hi    = lo + 11'd1;
      frac  = longint'(phase[20:5]);
      a     = longint'(wave_mem[wave_sel][lo]);
      b     = longint'(wave_mem[wave_sel][hi]);
      blend = a * (64'sd65536 - frac) + b * frac;
      prod  = (blend * gain_q15 + 64'sd1073741824) >>> 31;
      if (prod > 64'sd32767) prod = 64'sd32767;
      else if (prod < -64'sd32768) prod = -64'sd32768;
      pending_samples.push_back(prod[15:0]);
      tick_count++;
    endfunction

    function void check_sample(logic signed [15:0] got);
      logic signed [15:0] want;
      if (pending_samples.size() == 0) begin
        $display("%0t: sample beat %0d with none expected", $time, got);
        errors++;
        return;
      end
      want = pending_samples.pop_front();
      compared++;
      if (got !== want) begin
        $display("%0t: sample mismatch, expected %0d, got %0d", $time, want, got);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_samples.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_write;
  wpo_pkg::cfg_reg_t   cfg_index;
  logic [30:0]         cfg_data;
  logic                item_valid;
  logic                item_ready;
  logic                mode;
  logic [1:0]          table_select;
  logic [10:0]         table_addr;
  logic signed [15:0]  table_value;
  logic                sample_valid;
  logic                sample_ready;
  logic signed [15:0]  sample;

  osc_sample_tracker   tracker;
  bit                  tx_steady = 1'b0;
  bit                  rx_steady = 1'b0;
  int                  rx_hold = 0;
  int unsigned         settings = 0;
  int unsigned         sent_items = 0;

  wavetable_phase_oscillator_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .mode         (mode),
    .table_select (table_select),
    .table_addr   (table_addr),
    .table_value  (table_value),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && sample_valid && sample_ready) begin
      tracker.check_sample(sample);
    end
  end

  // sample sink: random stall per beat unless rx_steady, plus one long hold on request
  initial begin : sink
    int stall;
    sample_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = rx_steady ? 0 : int'($urandom_range(7, 0));
      if (rx_hold != 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end
      if (stall != 0) begin
        sample_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      sample_ready <= 1'b1;
      @(posedge clk);
      while (!sample_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic drive_item(input wpo_pkg::item_mode_t m, input logic [1:0] sel,
                            input logic [10:0] addr, input logic signed [15:0] val);
    int gap;
    gap = tx_steady ? 0 : int'($urandom_range(7, 0));
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid   <= 1'b1;
    mode         <= m;
    table_select <= sel;
    table_addr   <= addr;
    table_value  <= val;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    tracker.accept_item(m, sel, addr, val);
    sent_items++;
    @(negedge clk);
  endtask

  // load the two entries the tick will blend if they were never written, then send the tick
  task automatic send_tick();
    logic [10:0] lo;
    logic [10:0] hi;
    tracker.next_reads(lo, hi);
    if (!tracker.loaded[tracker.wave_sel][lo]) begin
      drive_item(wpo_pkg::MODE_WRITE, tracker.wave_sel, lo, 16'($urandom));
    end
    if (!tracker.loaded[tracker.wave_sel][hi]) begin
      drive_item(wpo_pkg::MODE_WRITE, tracker.wave_sel, hi, 16'($urandom));
    end
    drive_item(wpo_pkg::MODE_TICK, 2'($urandom), 11'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input wpo_pkg::cfg_reg_t idx, input logic [30:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    tracker.configure(idx, data);
    @(negedge clk);
  endtask

  // unused upper data bits carry noise
  task automatic set_regs(input logic [30:0] step, input logic [6:0] cents,
                          input wave_t wave, input logic [15:0] level);
    logic [30:0] noise;
    noise = 31'($urandom);
    write_reg(wpo_pkg::REG_BASE_STEP, step);
    write_reg(wpo_pkg::REG_DETUNE, {noise[30:7], cents});
    write_reg(wpo_pkg::REG_WAVEFORM, {noise[30:2], wave});
    write_reg(wpo_pkg::REG_GAIN, {noise[30:16], level});
    cfg_write <= 1'b0;
    settings++;
  endtask

  initial begin : stimulus
    logic [30:0] step;
    logic [6:0]  cents;
    wave_t       wave;
    logic [15:0] level;
    int unsigned phase_end;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = wpo_pkg::REG_BASE_STEP;
    cfg_data     = '0;
    item_valid   = 1'b0;
    mode         = wpo_pkg::MODE_TICK;
    table_select = '0;
    table_addr   = '0;
    table_value  = '0;
    tracker = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // extremes: a full step lands on entry 1023, a second on the last entry, whose neighbour wraps to 0
    set_regs(31'h7FFF_FFFF, 7'd0, WAVE_SINE, wpo_pkg::GAIN_UNITY);
    drive_item(wpo_pkg::MODE_WRITE, WAVE_SINE, 11'd0, 16'sh8000);
    drive_item(wpo_pkg::MODE_WRITE, WAVE_SINE, 11'd2047, 16'sh7FFF);
    drive_item(wpo_pkg::MODE_WRITE, WAVE_SINE, 11'd1023, 16'sh8000);
    drive_item(wpo_pkg::MODE_WRITE, WAVE_SINE, 11'd1024, 16'sh7FFF);
    repeat (4) send_tick();
    drive_item(wpo_pkg::MODE_WRITE, WAVE_TRIANGLE, 11'd2047, 16'sh8000);
    drive_item(wpo_pkg::MODE_WRITE, WAVE_TRIANGLE, 11'd0, 16'sh7FFF);
    drain();
    // detune below range, gain above unity
    set_regs(31'h0001_2345, 7'h40, WAVE_TRIANGLE, 16'hFFFF);
    repeat (3) send_tick();
    drain();
    // detune above range, zero gain
    set_regs(31'h0800_0000, 7'h3F, WAVE_SAW, 16'h0000);
    repeat (2) send_tick();
    drain();
    set_regs(31'd0, 7'h7F, WAVE_SQUARE, 16'h8001);
    repeat (2) send_tick();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          step = 31'($urandom_range(1 << 20, 1));
          cents = 7'($urandom);
          wave = wave_t'(2'($urandom));
          level = 16'($urandom);
        end
        1: begin
          step = 31'($urandom);
          cents = 7'h4E;
          wave = WAVE_SAW;
          level = wpo_pkg::GAIN_UNITY;
        end
        2: begin
          step = 31'h7FFF_FFFF;
          cents = 7'd50;
          wave = WAVE_SQUARE;
          level = 16'h0000;
        end
        3: begin
          step = 31'($urandom_range(1 << 16, 1));
          cents = 7'($urandom);
          wave = WAVE_TRIANGLE;
          level = 16'hFFFF;
        end
        4: begin
          step = 31'd0;
          cents = 7'd0;
          wave = WAVE_SINE;
          level = 16'($urandom_range(32768, 0));
        end
        default: begin
          step = ($urandom_range(1, 0) == 1) ? 31'($urandom)
                                             : 31'($urandom_range(1 << 22, 1));
          cents = 7'($urandom);
          wave = wave_t'(2'($urandom));
          level = ($urandom_range(3, 0) == 0) ? wpo_pkg::GAIN_UNITY : 16'($urandom);
        end
      endcase
      drain();
      set_regs(step, cents, wave, level);
      tx_steady = (p == 1 || p == 3 || p == 6);
      rx_steady = (p == 2 || p == 6 || p == 7);
      phase_end = sent_items + 190;
      for (int n = 0; sent_items < phase_end; n++) begin
        // long sink hold while beats keep coming: pipeline fills, input stalls
        if (p == 3 && n == 40) rx_hold = 150;
        if (p == 5 && n == 60) drain();
        if ($urandom_range(9, 0) < 3) begin
          drive_item(wpo_pkg::MODE_WRITE, 2'($urandom), 11'($urandom), 16'($urandom));
        end else begin
          send_tick();
        end
      end
    end

    drain();
    $display("Covered %0d ticks and %0d table writes over %0d register settings,",
             tracker.tick_count, tracker.write_count, settings);
    $display("with detune and gain saturation, table wrap and long output stalls.");
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
